FILE: sv/swav_pkg.sv
// Shared types and constants for the sensor window average validator.
// Used by swav_ctrl, swav_dp and the top level; depends on nothing else.
package swav_pkg;

   localparam int unsigned DATA_W = 32;   // Q16.16 sample width
   localparam int unsigned FILL_W = 5;    // window fill / length width
   localparam int unsigned CSR_AW = 4;    // CSR byte address width

   // CSR register indexes (byte address bits [3:2])
   localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
   localparam logic [1:0] REG_LOWER_LIMIT   = 2'd1;
   localparam logic [1:0] REG_UPPER_LIMIT   = 2'd2;

   localparam logic [FILL_W-1:0] LENGTH_RESET = 5'd4;
   localparam logic [DATA_W-1:0] LOWER_RESET  = 32'h8000_0000;
   localparam logic [DATA_W-1:0] UPPER_RESET  = 32'h7FFF_FFFF;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture input beat, start repeat scan
      logic rd_issue;    // read window entry, step pointer toward older
      logic update;      // accept/reject decision, window write, fill update
      logic div_start;   // load divider with |sum|
      logic div_step;    // one restoring division step
      logic out_load;    // load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [FILL_W-1:0] scan_cnt;   // entries to compare for stuck check
      logic [FILL_W-1:0] upd_fill;   // fill after the pending update
      logic              avg_need;   // window full and fault not active
   } status_type;

endpackage

FILE: sv/swav_ctrl.sv
// Sequencer for the sensor window average validator.
// Drives swav_dp through cmd_type and owns the stream handshakes; uses swav_pkg.
module swav_ctrl import swav_pkg::*; #(
   parameter int unsigned SUM_W = 36
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int unsigned CNT_W = $clog2(SUM_W + 1);

   typedef enum logic [8:0] {
      ST_IDLE     = 9'b000000001,
      ST_SCAN     = 9'b000000010,
      ST_SCAN_END = 9'b000000100,
      ST_UPDATE   = 9'b000001000,
      ST_SUM      = 9'b000010000,
      ST_SUM_END  = 9'b000100000,
      ST_DIV_LOAD = 9'b001000000,
      ST_DIVIDE   = 9'b010000000,
      ST_FINISH   = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_W'(status.scan_cnt);
               state_in = (status.scan_cnt == '0) ? ST_UPDATE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.rd_issue = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) state_in = ST_SCAN_END;
         end
         ST_SCAN_END: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            cnt_in     = CNT_W'(status.upd_fill);
            state_in   = (status.upd_fill == '0) ? ST_DIV_LOAD : ST_SUM;
         end
         ST_SUM: begin
            cmd.rd_issue = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) state_in = ST_SUM_END;
         end
         ST_SUM_END: begin
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            if (status.avg_need) begin
               cmd.div_start = 1'b1;
               cnt_in        = CNT_W'(SUM_W);
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result beat valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load)    out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: sv/swav_dp.sv
// Datapath: circular window memory, range/stuck checks, running sum, serial divider.
// Controlled by swav_ctrl through cmd_type/status_type from swav_pkg.
module swav_dp import swav_pkg::*; #(
   parameter int unsigned WINDOW_MAX   = 16,
   parameter int unsigned REPEAT_COUNT = 3,
   parameter int unsigned SUM_W        = 36
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic        [DATA_W-1:0] in_sample,
   input  logic                     in_suppressed,
   input  logic                     in_active,
   input  logic        [FILL_W-1:0] cfg_length,
   input  logic signed [DATA_W-1:0] cfg_lower,
   input  logic signed [DATA_W-1:0] cfg_upper,
   output logic                     out_accepted,
   output logic                     out_avg_valid,
   output logic        [DATA_W-1:0] out_average,
   output logic        [FILL_W-1:0] out_fill
);

   localparam int unsigned PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic signed [DATA_W-1:0] mem_ff [WINDOW_MAX];
   logic signed [DATA_W-1:0] rd_data_ff;
   logic                     rd_vld_ff;
   logic [PTR_W-1:0]         rd_addr_ff, rd_addr_in;
   logic [PTR_W-1:0]         head_ff, head_inc, rd_addr_dec;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic signed [DATA_W-1:0] x_ff;
   logic                     supp_ff, act_ff;
   logic                     match_ff, accepted_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic [SUM_W-1:0]         quo_ff;
   logic [FILL_W-1:0]        rem_ff;
   logic                     neg_ff;
   logic                     out_accepted_ff, out_avg_valid_ff;
   logic [DATA_W-1:0]        out_average_ff;
   logic [FILL_W-1:0]        out_fill_ff;

   logic [FILL_W-1:0] eff_len, rep_len, upd_fill;
   logic              in_range, stuck, take;
   logic [FILL_W:0]   fill_p1, rem_sh;
   logic [DATA_W-1:0] quo_s;

   // effective window length: 0 acts as 1, clamp to WINDOW_MAX
   always_comb begin
      if (cfg_length == '0)                    eff_len = FILL_W'(1);
      else if (32'(cfg_length) > WINDOW_MAX)   eff_len = FILL_W'(WINDOW_MAX);
      else                                     eff_len = cfg_length;
   end

   assign rep_len = FILL_W'(REPEAT_COUNT);

   // circular pointer arithmetic
   assign head_inc    = (head_ff == PTR_W'(WINDOW_MAX - 1)) ? '0 : head_ff + PTR_W'(1);
   assign rd_addr_dec = (rd_addr_ff == '0) ? PTR_W'(WINDOW_MAX - 1) : rd_addr_ff - PTR_W'(1);

   // accept decision and fill after update
   assign in_range = (x_ff >= cfg_lower) && (x_ff <= cfg_upper);
   assign stuck    = (fill_ff >= FILL_W'(2)) && match_ff;
   assign take     = in_range && !stuck;
   assign fill_p1  = {1'b0, fill_ff} + (FILL_W+1)'(1);

   always_comb begin
      if (take)         upd_fill = (fill_p1 > {1'b0, eff_len}) ? eff_len : fill_p1[FILL_W-1:0];
      else if (supp_ff) upd_fill = fill_ff;
      else              upd_fill = '0;
   end

   assign fill_in = cmd.update ? upd_fill : fill_ff;

   // status to controller
   assign status.scan_cnt = (fill_ff < FILL_W'(2)) ? '0 :
                            ((fill_ff < rep_len) ? fill_ff : rep_len);
   assign status.upd_fill = upd_fill;
   assign status.avg_need = (fill_ff == eff_len) && !act_ff;

   // read pointer: newest entry first, walking toward older
   always_comb begin
      rd_addr_in = rd_addr_ff;
      if (cmd.load)          rd_addr_in = head_ff;
      else if (cmd.update)   rd_addr_in = take ? head_inc : head_ff;
      else if (cmd.rd_issue) rd_addr_in = rd_addr_dec;
   end

   // window memory
   always_ff @(posedge clock) begin
      if (cmd.update && take) mem_ff[head_inc] <= x_ff;
      if (cmd.rd_issue)       rd_data_ff <= mem_ff[rd_addr_ff];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         fill_ff    <= '0;
         rd_vld_ff  <= 1'b0;
         rd_addr_ff <= '0;
      end else begin
         if (cmd.update && take) head_ff <= head_inc;
         fill_ff    <= fill_in;
         rd_vld_ff  <= cmd.rd_issue;
         rd_addr_ff <= rd_addr_in;
      end
   end

   // item capture, compare and accumulate
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= in_sample;
         supp_ff <= in_suppressed;
         act_ff  <= in_active;
      end
      if (cmd.load)                             match_ff <= 1'b1;
      else if (rd_vld_ff && rd_data_ff != x_ff) match_ff <= 1'b0;
      if (cmd.update)     acc_ff <= '0;
      else if (rd_vld_ff) acc_ff <= acc_ff + SUM_W'(rd_data_ff);
      if (cmd.update)     accepted_ff <= take;
   end

   // restoring divider, one quotient bit per step
   assign rem_sh = {rem_ff, quo_ff[SUM_W-1]};

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         neg_ff <= acc_ff[SUM_W-1];
         quo_ff <= acc_ff[SUM_W-1] ? SUM_W'(-acc_ff) : SUM_W'(acc_ff);
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, eff_len}) begin
            rem_ff <= FILL_W'(rem_sh - {1'b0, eff_len});
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[FILL_W-1:0];
            quo_ff <= {quo_ff[SUM_W-2:0], 1'b0};
         end
      end
   end

   // sign restore, truncation toward zero
   assign quo_s = neg_ff ? (~quo_ff[DATA_W-1:0] + DATA_W'(1)) : quo_ff[DATA_W-1:0];

   // result register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_accepted_ff  <= accepted_ff;
         out_avg_valid_ff <= status.avg_need;
         out_average_ff   <= status.avg_need ? quo_s : '0;
         out_fill_ff      <= fill_ff;
      end
   end

   assign out_accepted  = out_accepted_ff;
   assign out_avg_valid = out_avg_valid_ff;
   assign out_average   = out_average_ff;
   assign out_fill      = out_fill_ff;

endmodule

FILE: sv/sensor_window_average_validator_unit.sv
// Top level of the sensor window average validator: CSR block, sequencer, datapath.
// Depends on swav_pkg, swav_ctrl and swav_dp.
//
//  channel | direction | beat contents
//  req     | in        | tdata: sample; tuser: fault_suppressed, fault_active
//  rsp     | out       | tdata: average_value, window_fill; tuser: accepted, avg valid
//  csr     | in/out    | APB: window_length @0x0, lower_limit @0x4, upper_limit @0x8
//
// One beat at a time: the sequencer takes the beat, compares it with the newest
// n = min(REPEAT_COUNT, fill) window entries for the stuck check (n = 0 when fill < 2),
// updates the window, sums the f entries held after the update and, when an average is
// produced, divides the SUM_W = 32 + clog2(min(WINDOW_MAX,31)) bit |sum| by the length in
// the bit-serial divider; all window reads use the single memory read port. Synchronous
// reset empties the window; a result waits in the output register while the next beat
// is taken, and the sequencer stalls at its last step while that register is still full.
module sensor_window_average_validator_unit import swav_pkg::*; #(
   parameter int unsigned WINDOW_MAX   = 16,
   parameter int unsigned REPEAT_COUNT = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,    // [31:0] sample
   input  logic [1:0]        req_tuser,    // [0] fault_suppressed, [1] fault_active
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [39:0]       rsp_tdata,    // [31:0] average_value, [36:32] window_fill
   output logic [1:0]        rsp_tuser,    // [0] sample_accepted, [1] average_valid
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int unsigned FILL_MAX = (WINDOW_MAX < 31) ? WINDOW_MAX : 31;
   localparam int unsigned SUM_W    = DATA_W + $clog2(FILL_MAX);

   logic [FILL_W-1:0]        length_ff;
   logic signed [DATA_W-1:0] lower_ff, upper_ff;
   logic                     csr_wr;
   logic [1:0]               csr_idx;

   cmd_type           cmd;
   status_type        status;
   logic              out_accepted, out_avg_valid;
   logic [DATA_W-1:0] out_average;
   logic [FILL_W-1:0] out_fill;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= LENGTH_RESET;
         lower_ff  <= LOWER_RESET;
         upper_ff  <= UPPER_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_WINDOW_LENGTH: length_ff <= csr_pwdata[FILL_W-1:0];
            REG_LOWER_LIMIT:   lower_ff  <= csr_pwdata;
            REG_UPPER_LIMIT:   upper_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_WINDOW_LENGTH: csr_prdata = {{(32-FILL_W){1'b0}}, length_ff};
         REG_LOWER_LIMIT:   csr_prdata = lower_ff;
         REG_UPPER_LIMIT:   csr_prdata = upper_ff;
         default:           csr_prdata = '0;
      endcase
   end

   swav_ctrl #(
      .SUM_W (SUM_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   swav_dp #(
      .WINDOW_MAX   (WINDOW_MAX),
      .REPEAT_COUNT (REPEAT_COUNT),
      .SUM_W        (SUM_W)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .in_sample     (req_tdata),
      .in_suppressed (req_tuser[0]),
      .in_active     (req_tuser[1]),
      .cfg_length    (length_ff),
      .cfg_lower     (lower_ff),
      .cfg_upper     (upper_ff),
      .out_accepted  (out_accepted),
      .out_avg_valid (out_avg_valid),
      .out_average   (out_average),
      .out_fill      (out_fill)
   );

   // result beat packing
   assign rsp_tdata = {3'b000, out_fill, out_average};
   assign rsp_tuser = {out_avg_valid, out_accepted};

   // one item in flight: no accept right after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted on consecutive cycles");

   // a withheld average reads as zero
   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[31:0] == '0)
      else $error("average nonzero while not valid");

   // an accepted sample leaves the window non-empty
   a_accept_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[36:32] != '0)
      else $error("accepted sample with empty window");

   // a valid average needs a non-empty window
   a_valid_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata[36:32] != '0)
      else $error("average valid with empty window");

endmodule
